// ===== src/rabs_pkg.sv =====
// Shared constants, types and register codes of the running-average background subtractor.
`default_nettype none
package rabs_pkg;

    // Model store geometry
    localparam int PIXELS   = 131072;
    localparam int ADDR_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int IDX_W    = 17;

    // Pixel and model formats
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int CMP_CHAN = 3;
    localparam int MODEL_W  = 16;
    localparam int SQ_W     = 2 * MODEL_W;
    localparam int SUM_W    = SQ_W + 2;

    // Configuration registers
    localparam int RATE_W      = 16;
    localparam int LIMIT_W     = 18;
    localparam int CFG_DATA_W  = 18;
    localparam int REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_BLEND_RATE     = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_DISTANCE_LIMIT = 2'd1;
    localparam logic [RATE_W-1:0]  BLEND_RATE_RESET     = 16'd3277;
    localparam logic [LIMIT_W-1:0] DISTANCE_LIMIT_RESET = 18'd900;

    // Input mode codes and mask codes
    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_SUBTRACT = 1'b1;
    localparam logic [CHAN_W-1:0] MASK_FG = 8'd255;
    localparam logic [CHAN_W-1:0] MASK_BG = 8'd0;

    // Queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified operation for the back end
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_UPDATE,
        OP_MISS
    } op_t;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]  pix_t;
    typedef logic [NUM_CHAN-1:0][MODEL_W-1:0] entry_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        pix_t              pix;
    } cmd_t;

    typedef struct packed {
        logic [RATE_W-1:0]  blend_rate;
        logic [LIMIT_W-1:0] distance_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ===== src/rabs_front.sv =====
// Front end: accepts input words, classifies them and hands commands to the queue.
`default_nettype none
module rabs_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          mode,
    input  wire logic [rabs_pkg::IDX_W-1:0]    pixel_index,
    input  wire logic [rabs_pkg::CHAN_W-1:0]   chan_zero,
    input  wire logic [rabs_pkg::CHAN_W-1:0]   chan_one,
    input  wire logic [rabs_pkg::CHAN_W-1:0]   chan_two,
    input  wire logic [rabs_pkg::CHAN_W-1:0]   chan_three,
    output logic                               q_push,
    input  wire logic                          q_full,
    output rabs_pkg::cmd_t                     q_cmd
);

    logic           valid_reg;
    logic           valid_next;
    rabs_pkg::cmd_t cmd_reg;
    rabs_pkg::cmd_t cmd_next;
    logic           in_range;
    logic           keep;
    logic           accept;

    // Classify the incoming word
    always_comb
    begin
        in_range = (32'(pixel_index) < rabs_pkg::PIXELS);
        cmd_next.addr   = pixel_index[rabs_pkg::ADDR_W-1:0];
        cmd_next.pix[0] = chan_zero;
        cmd_next.pix[1] = chan_one;
        cmd_next.pix[2] = chan_two;
        cmd_next.pix[3] = chan_three;
        if (mode == rabs_pkg::MODE_SUBTRACT)
        begin
            cmd_next.op = in_range ? rabs_pkg::OP_UPDATE : rabs_pkg::OP_MISS;
            keep        = 1'b1;
        end
        else
        begin
            cmd_next.op = rabs_pkg::OP_LOAD;
            // drop loads outside the store
            keep        = in_range;
        end
    end

    // Hand the held command to the queue when it has room
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_cmd  = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = keep;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until it moves on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rabs_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module rabs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire rabs_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                empty,
    output rabs_pkg::cmd_t      head
);

    rabs_pkg::cmd_t                slots [rabs_pkg::QUEUE_DEPTH];
    logic [rabs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rabs_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [rabs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rabs_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [rabs_pkg::QCNT_W-1:0]   count_reg;
    logic [rabs_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == rabs_pkg::QCNT_W'(rabs_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rabs_pkg::QPTR_W'(rabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rabs_pkg::QPTR_W'(rabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/rabs_back.sv =====
// Back end: model store read-modify-write pipeline, distance test and result buffer.
`default_nettype none
module rabs_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rabs_pkg::cfg_t               cfg,
    input  wire logic                         q_empty,
    input  wire rabs_pkg::cmd_t               q_head,
    output logic                              q_pop,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [rabs_pkg::CHAN_W-1:0]       mask_value
);

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int PEND_W    = OCNT_W + 1;
    localparam int ROUND_HALF = 32768;

    // Model store
    rabs_pkg::entry_t              model_mem [rabs_pkg::PIXELS];
    rabs_pkg::entry_t              rdata_reg;

    // Read stage
    logic                          s1_valid_reg;
    rabs_pkg::cmd_t                s1_cmd_reg;
    logic                          fwd_hit_reg;
    rabs_pkg::entry_t              fwd_data_reg;

    // Distance stage
    logic                          s2_valid_reg;
    logic                          s2_miss_reg;
    logic [rabs_pkg::SQ_W-1:0]     s2_sq_reg [rabs_pkg::CMP_CHAN];

    // Result buffer
    logic [rabs_pkg::CHAN_W-1:0]   out_mem [OUT_DEPTH];
    logic [OPTR_W-1:0]             out_wr_reg;
    logic [OPTR_W-1:0]             out_rd_reg;
    logic [OCNT_W-1:0]             out_count_reg;
    logic [OCNT_W-1:0]             out_count_next;

    logic                          issue;
    logic [PEND_W-1:0]             pending;
    logic                          s1_result;
    logic                          s1_write;
    logic                          s2_result;
    rabs_pkg::entry_t              model;
    rabs_pkg::entry_t              new_entry;
    logic [rabs_pkg::MODEL_W:0]    inv_rate;
    logic [rabs_pkg::MODEL_W-1:0]  p_chan  [rabs_pkg::NUM_CHAN];
    logic [rabs_pkg::MODEL_W-1:0]  diff    [rabs_pkg::CMP_CHAN];
    logic [rabs_pkg::SQ_W-1:0]     sq      [rabs_pkg::CMP_CHAN];
    logic [31:0]                   prod_a  [rabs_pkg::NUM_CHAN];
    logic [32:0]                   prod_b  [rabs_pkg::NUM_CHAN];
    logic [32:0]                   acc     [rabs_pkg::NUM_CHAN];
    logic [rabs_pkg::SUM_W-1:0]    dist_sum;
    logic [rabs_pkg::SUM_W-1:0]    limit_scaled;
    logic [rabs_pkg::CHAN_W-1:0]   mask;
    logic                          out_push;
    logic                          out_pop;

    // Issue only when the result buffer has room for every word in flight
    assign s1_result = s1_valid_reg && (s1_cmd_reg.op != rabs_pkg::OP_LOAD);
    assign s1_write  = s1_valid_reg && (s1_cmd_reg.op != rabs_pkg::OP_MISS);
    assign s2_result = s2_valid_reg;
    assign pending   = PEND_W'(out_count_reg) + PEND_W'(s1_result) + PEND_W'(s2_result);
    assign issue     = !q_empty && (pending < PEND_W'(OUT_DEPTH));
    assign q_pop     = issue;

    // Read the model entry at issue
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg <= model_mem[q_head.addr];
        end
        if (s1_write)
        begin
            model_mem[s1_cmd_reg.addr] <= new_entry;
        end
    end

    // Squared differences and blend against the model
    always_comb
    begin
        model    = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        inv_rate = 17'h10000 - {1'b0, cfg.blend_rate};
        for (int c = 0; c < rabs_pkg::NUM_CHAN; c++)
        begin
            p_chan[c] = {s1_cmd_reg.pix[c], 8'h00};
            prod_a[c] = {16'h0000, cfg.blend_rate} * {16'h0000, p_chan[c]};
            prod_b[c] = {16'h0000, inv_rate} * {17'h00000, model[c]};
            acc[c]    = {1'b0, prod_a[c]} + prod_b[c] + 33'(ROUND_HALF);
        end
        for (int c = 0; c < rabs_pkg::CMP_CHAN; c++)
        begin
            diff[c] = (model[c] >= p_chan[c]) ? (model[c] - p_chan[c])
                                              : (p_chan[c] - model[c]);
            sq[c]   = {16'h0000, diff[c]} * {16'h0000, diff[c]};
        end
        for (int c = 0; c < rabs_pkg::NUM_CHAN; c++)
        begin
            if (s1_cmd_reg.op == rabs_pkg::OP_LOAD)
            begin
                new_entry[c] = p_chan[c];
            end
            else
            begin
                new_entry[c] = acc[c][31:16];
            end
        end
    end

    // Advance the pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_result;
            // forward the entry being written when the next item reads it
            fwd_hit_reg  <= issue && s1_write && (q_head.addr == s1_cmd_reg.addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_cmd_reg <= q_head;
        end
        fwd_data_reg <= new_entry;
        s2_miss_reg  <= (s1_cmd_reg.op == rabs_pkg::OP_MISS);
        for (int c = 0; c < rabs_pkg::CMP_CHAN; c++)
        begin
            s2_sq_reg[c] <= sq[c];
        end
    end

    // Sum distances and compare with the threshold; misses give background
    always_comb
    begin
        dist_sum = '0;
        for (int c = 0; c < rabs_pkg::CMP_CHAN; c++)
        begin
            dist_sum = dist_sum + rabs_pkg::SUM_W'(s2_sq_reg[c]);
        end
        limit_scaled = {cfg.distance_limit, 16'h0000};
        if (!s2_miss_reg && (dist_sum > limit_scaled))
        begin
            mask = rabs_pkg::MASK_FG;
        end
        else
        begin
            mask = rabs_pkg::MASK_BG;
        end
    end

    // Result buffer
    assign out_push   = s2_result;
    assign empty      = (out_count_reg == '0);
    assign out_pop    = pop && !empty;
    assign mask_value = out_mem[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_push)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem[out_wr_reg] <= mask;
        end
    end

    // Credit accounting keeps the buffer from overflowing
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= PEND_W'(OUT_DEPTH))
        else $error("results in flight exceed result buffer depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count_reg < OCNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full buffer");

    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward hit without an issued item");

    a_fwd_addr: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (s1_cmd_reg.addr == $past(s1_cmd_reg.addr)))
        else $error("forward hit for a different address");

endmodule
`default_nettype wire

// ===== src/running_average_background_subtractor_unit.sv =====
// Top level of the running-average background subtractor with its configuration registers.
//
// Input channel: push/full carries one pixel word (mode, pixel_index, four channel
// bytes); a word is taken at a clock edge with push high and full low.
// Result channel: empty/pop carries one mask_value word per subtract word (255 for
// foreground, 0 for background); load words give no result.
// Configuration: write_enable, reg_index, write_data write blend_rate (index 0) or
// distance_limit (index 1) at any edge with write_enable high; other indexes are
// ignored. Write only while the block is idle.
// Path: input stage, command queue, read stage, distance stage, result buffer. Throughput:
// one word per clock while pop stays high, set by the model store doing one read and one
// write per cycle; back-to-back words on the same pixel are forwarded.
// Reset: control state clears and the registers return to 3277 and 900. The model
// store is not cleared; every pixel must be loaded before it is subtracted.
// Stall: the result buffer holds four words; when pop stays low the back end stops
// issuing, the command queue and the input stage fill, and full rises.
`default_nettype none
module running_average_background_subtractor_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                mode,
    input  wire logic [rabs_pkg::IDX_W-1:0]          pixel_index,
    input  wire logic [rabs_pkg::CHAN_W-1:0]         chan_zero,
    input  wire logic [rabs_pkg::CHAN_W-1:0]         chan_one,
    input  wire logic [rabs_pkg::CHAN_W-1:0]         chan_two,
    input  wire logic [rabs_pkg::CHAN_W-1:0]         chan_three,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [rabs_pkg::CHAN_W-1:0]              mask_value,
    input  wire logic                                write_enable,
    input  wire logic [rabs_pkg::REG_INDEX_W-1:0]    reg_index,
    input  wire logic [rabs_pkg::CFG_DATA_W-1:0]     write_data
);

    rabs_pkg::cfg_t  cfg_reg;
    logic            q_push;
    logic            q_full;
    rabs_pkg::cmd_t  q_cmd;
    logic            q_pop;
    logic            q_empty;
    rabs_pkg::cmd_t  q_head;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_rate     <= rabs_pkg::BLEND_RATE_RESET;
            cfg_reg.distance_limit <= rabs_pkg::DISTANCE_LIMIT_RESET;
        end
        else if (write_enable)
        begin
            case (reg_index)
                rabs_pkg::REG_BLEND_RATE:
                begin
                    cfg_reg.blend_rate <= write_data[rabs_pkg::RATE_W-1:0];
                end
                rabs_pkg::REG_DISTANCE_LIMIT:
                begin
                    cfg_reg.distance_limit <= write_data[rabs_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    rabs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .pixel_index (pixel_index),
        .chan_zero   (chan_zero),
        .chan_one    (chan_one),
        .chan_two    (chan_two),
        .chan_three  (chan_three),
        .q_push      (q_push),
        .q_full      (q_full),
        .q_cmd       (q_cmd)
    );

    rabs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .full     (q_full),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    rabs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .mask_value (mask_value)
    );

endmodule
`default_nettype wire

// ===== test/running_average_background_subtractor_unit_test.sv =====
// Self-checking testbench of the running-average background subtractor: stimulus, model, checks.
`timescale 1ns / 1ps

module running_average_background_subtractor_unit_test;

    import rabs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 10;
    localparam int IDLE_PCT       = 17;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_WORDS    = 100;
    localparam int STEADY_WORDS   = 200;
    localparam int PRESSURE_WORDS = 60;
    localparam int PRESSURE_HOLD  = 120;
    localparam int POOL_SIZE      = 32;
    localparam int REPORT_CAP     = 40;
    localparam int WATCHDOG_NS    = 3_000_000;

    // Register indexes past the end of the map; writes there must do nothing
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LOW  = '0;
    localparam logic [IDX_W-1:0] IDX_HIGH = '1;
    localparam logic [IDX_W-1:0] IDX_ODD  = 17'h15555;
    localparam logic [IDX_W-1:0] IDX_EVEN = 17'h0AAAA;
    localparam logic [IDX_W-1:0] IDX_EDGE = 17'h1F0F0;

    typedef struct {
        logic [CHAN_W-1:0] mask;
        logic [IDX_W-1:0]  pixel;
        int                serial;
    } mask_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic                   mode;
    logic [IDX_W-1:0]       pixel_index;
    logic [CHAN_W-1:0]      chan_zero;
    logic [CHAN_W-1:0]      chan_one;
    logic [CHAN_W-1:0]      chan_two;
    logic [CHAN_W-1:0]      chan_three;
    logic                   empty;
    logic                   pop;
    logic [CHAN_W-1:0]      mask_value;
    logic                   write_enable;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  write_data;

    // Background model mirror, register copies and pending masks
    entry_t            bg_model [int unsigned];
    logic [RATE_W-1:0]  rate_now  = BLEND_RATE_RESET;
    logic [LIMIT_W-1:0] limit_now = DISTANCE_LIMIT_RESET;
    mask_word_t        mask_expected [$];
    int unsigned       pixel_pool [$];
    logic [IDX_W-1:0]  last_pixel;

    bit steady_flow      = 1'b0;
    int mask_hold_cycles = 0;

    int mismatch_count    = 0;
    int loads_sent        = 0;
    int subtracts_sent    = 0;
    int masks_checked     = 0;
    int fg_seen           = 0;
    int full_stall_cycles = 0;
    int settings_applied  = 0;

    running_average_background_subtractor_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .pixel_index  (pixel_index),
        .chan_zero    (chan_zero),
        .chan_one     (chan_one),
        .chan_two     (chan_two),
        .chan_three   (chan_three),
        .empty        (empty),
        .pop          (pop),
        .mask_value   (mask_value),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Advance the model by one accepted pixel word and queue its mask if any
    function automatic void predict_pixel(input logic m, input logic [IDX_W-1:0] idx,
                                          input pix_t px);
        entry_t     old_e;
        entry_t     new_e;
        logic [63:0] mval;
        logic [63:0] pval;
        logic [63:0] diff;
        logic [63:0] dist_total;
        logic [63:0] acc;
        mask_word_t word;
        if (m == MODE_LOAD)
        begin
            if (idx < PIXELS)
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    new_e[c] = {px[c], 8'h00};
                end
                bg_model[idx] = new_e;
            end
            return;
        end
        word.pixel  = idx;
        word.serial = subtracts_sent;
        if (idx >= PIXELS)
        begin
            word.mask = MASK_BG;
            mask_expected.push_back(word);
            return;
        end
        old_e      = bg_model[idx];
        dist_total = '0;
        for (int c = 0; c < CMP_CHAN; c++)
        begin
            mval       = 64'(old_e[c]);
            pval       = 64'({px[c], 8'h00});
            diff       = (mval >= pval) ? mval - pval : pval - mval;
            dist_total = dist_total + diff * diff;
        end
        word.mask = (dist_total > (64'(limit_now) << 16)) ? MASK_FG : MASK_BG;
        mask_expected.push_back(word);
        // Blend each channel toward the pixel, rounding half up
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            mval = 64'(old_e[c]);
            pval = 64'({px[c], 8'h00});
            acc  = 64'(rate_now) * pval + (64'd65536 - 64'(rate_now)) * mval + 64'd32768;
            new_e[c] = acc[31:16];
        end
        bg_model[idx] = new_e;
    endfunction

    function automatic void apply_register(input logic [REG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_BLEND_RATE:     rate_now  = data[RATE_W-1:0];
            REG_DISTANCE_LIMIT: limit_now = data[LIMIT_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic void remember_pixel(input logic [IDX_W-1:0] idx);
        foreach (pixel_pool[k])
        begin
            if (pixel_pool[k] == idx)
            begin
                return;
            end
        end
        if (pixel_pool.size() < POOL_SIZE)
        begin
            pixel_pool.push_back(idx);
        end
        else
        begin
            pixel_pool[$urandom_range(0, POOL_SIZE - 1)] = idx;
        end
    endfunction

    // Offer one pixel word, hold it until taken, then update the model
    task automatic send_pixel(input logic m, input logic [IDX_W-1:0] idx, input pix_t px);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
            begin
                @(posedge clk);
            end
        end
        push        <= 1'b1;
        mode        <= m;
        pixel_index <= idx;
        chan_zero   <= px[0];
        chan_one    <= px[1];
        chan_two    <= px[2];
        chan_three  <= px[3];
        @(posedge clk);
        while (full !== 1'b0)
        begin
            full_stall_cycles++;
            @(posedge clk);
        end
        predict_pixel(m, idx, px);
        if (m == MODE_LOAD)
        begin
            loads_sent++;
            remember_pixel(idx);
        end
        else
        begin
            subtracts_sent++;
        end
        last_pixel = idx;
    endtask

    task automatic send_bytes(input logic m, input logic [IDX_W-1:0] idx,
                              input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                              input logic [CHAN_W-1:0] c2, input logic [CHAN_W-1:0] c3);
        send_pixel(m, idx, {c3, c2, c1, c0});
    endtask

    function automatic logic [CHAN_W-1:0] random_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return 8'd0;
        end
        if (r < 20)
        begin
            return 8'd255;
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    // Pick a byte close to the current model value so both mask outcomes occur
    function automatic logic [CHAN_W-1:0] near_byte(input logic [MODEL_W-1:0] model_chan);
        int val;
        val = int'(model_chan[15:8]) + int'(model_chan[7]) + $urandom_range(0, 24) - 12;
        if (val < 0)
        begin
            val = 0;
        end
        if (val > 255)
        begin
            val = 255;
        end
        return CHAN_W'(val);
    endfunction

    // Mostly subtracts on loaded pixels, often the same pixel back to back
    task automatic send_random_pixel();
        logic             m;
        logic [IDX_W-1:0] idx;
        pix_t             px;
        entry_t           cur;
        int unsigned      r;
        int unsigned      shape;
        r = $urandom_range(99);
        if (pixel_pool.size() == 0 || r < 12)
        begin
            m   = MODE_LOAD;
            idx = IDX_W'($urandom_range(0, 2**IDX_W - 1));
        end
        else if (r < 20)
        begin
            m   = MODE_LOAD;
            idx = IDX_W'(pixel_pool[$urandom_range(0, pixel_pool.size() - 1)]);
        end
        else
        begin
            m   = MODE_SUBTRACT;
            idx = (r < 50) ? last_pixel
                           : IDX_W'(pixel_pool[$urandom_range(0, pixel_pool.size() - 1)]);
        end
        shape = $urandom_range(99);
        if (m == MODE_SUBTRACT)
        begin
            cur = bg_model[idx];
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (m == MODE_SUBTRACT && shape < 55)
            begin
                px[c] = near_byte(cur[c]);
            end
            else
            begin
                px[c] = random_byte();
            end
        end
        send_pixel(m, idx, px);
    endtask

    // Drop push and wait until every mask is back and the pipeline is quiet
    task automatic settle_block();
        push <= 1'b0;
        while (mask_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        reg_index    <= index;
        write_data   <= data;
        @(posedge clk);
        apply_register(index, data);
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] rate_data,
                                     input logic [CFG_DATA_W-1:0] limit_data);
        write_register(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
        write_register(REG_BLEND_RATE, rate_data);
        write_register(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
        write_register(REG_DISTANCE_LIMIT, limit_data);
        write_enable <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Check each mask word against the oldest pending prediction
    always @(posedge clk)
    begin : mask_check
        mask_word_t want;
        if (rst_n === 1'b1)
        begin
            if (pop === 1'b1 && empty === 1'b0)
            begin
                if (mask_expected.size() == 0)
                begin
                    report_mismatch($sformatf("mask word 0x%02h with no subtract pending",
                                              mask_value));
                end
                else
                begin
                    want = mask_expected.pop_front();
                    masks_checked++;
                    if (mask_value === MASK_FG)
                    begin
                        fg_seen++;
                    end
                    if (mask_value !== want.mask)
                    begin
                        report_mismatch($sformatf(
                            "subtract #%0d pixel 0x%05h: mask 0x%02h, want 0x%02h",
                            want.serial, want.pixel, mask_value, want.mask));
                    end
                end
            end
            if (mask_hold_cycles > 0)
            begin
                pop <= 1'b0;
                mask_hold_cycles--;
            end
            else if (steady_flow)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Corners under the reset register values: extremes, threshold edge, same-pixel runs
    task automatic test_directed_defaults();
        send_bytes(MODE_LOAD,     IDX_LOW,  0, 0, 0, 0);
        send_bytes(MODE_LOAD,     IDX_HIGH, 255, 255, 255, 255);
        send_bytes(MODE_SUBTRACT, IDX_LOW,  255, 255, 255, 255);
        send_bytes(MODE_SUBTRACT, IDX_HIGH, 0, 0, 0, 0);
        send_bytes(MODE_SUBTRACT, IDX_HIGH, 0, 0, 0, 0);
        send_bytes(MODE_LOAD,     IDX_ODD,  100, 100, 100, 7);
        send_bytes(MODE_SUBTRACT, IDX_ODD,  130, 100, 100, 200);
        send_bytes(MODE_LOAD,     IDX_ODD,  100, 100, 100, 7);
        send_bytes(MODE_SUBTRACT, IDX_ODD,  130, 101, 100, 0);
        send_bytes(MODE_LOAD,     IDX_EVEN, 50, 60, 70, 80);
        send_bytes(MODE_SUBTRACT, IDX_EVEN, 50, 60, 70, 80);
        send_bytes(MODE_SUBTRACT, IDX_EVEN, 51, 60, 70, 80);
        send_bytes(MODE_LOAD,     IDX_EVEN, 1, 2, 3, 4);
        send_bytes(MODE_SUBTRACT, IDX_EVEN, 1, 2, 3, 4);
        settle_block();
    endtask

    // Largest distance against the top limits, zero rate, zero limit
    task automatic test_limit_extremes();
        program_registers(18'h0FFFF, 18'd195074);
        send_bytes(MODE_LOAD,     IDX_EDGE, 0, 0, 0, 0);
        send_bytes(MODE_SUBTRACT, IDX_EDGE, 255, 255, 255, 255);
        settle_block();
        program_registers(18'h00000, 18'd195075);
        send_bytes(MODE_LOAD,     IDX_EDGE, 0, 0, 0, 0);
        send_bytes(MODE_SUBTRACT, IDX_EDGE, 255, 255, 255, 255);
        send_bytes(MODE_SUBTRACT, IDX_EDGE, 255, 255, 255, 255);
        settle_block();
        program_registers(18'h2FFFF, 18'd0);
        send_bytes(MODE_LOAD,     IDX_EDGE, 9, 9, 9, 9);
        send_bytes(MODE_SUBTRACT, IDX_EDGE, 9, 9, 9, 9);
        send_bytes(MODE_SUBTRACT, IDX_EDGE, 9, 9, 10, 9);
        settle_block();
    endtask

    // Random traffic under a sequence of register settings, extremes first
    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] rate_pick;
        logic [CFG_DATA_W-1:0] limit_pick;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin rate_pick = 18'h00000; limit_pick = 18'd0;      end
                1: begin rate_pick = 18'h3FFFF; limit_pick = 18'h3FFFF;  end
                2: begin rate_pick = 18'h0FFFF; limit_pick = 18'd195075; end
                3: begin rate_pick = 18'h10001; limit_pick = 18'd195074; end
                4: begin rate_pick = 18'h08000; limit_pick = 18'd1;      end
                default:
                begin
                    rate_pick  = CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
                    limit_pick = ($urandom_range(1) == 0)
                                 ? CFG_DATA_W'($urandom_range(0, 4000))
                                 : CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
                end
            endcase
            program_registers(rate_pick, limit_pick);
            repeat (PHASE_WORDS) send_random_pixel();
            settle_block();
        end
    endtask

    // One long stretch with no idling on either side
    task automatic test_steady_stream();
        program_registers(CFG_DATA_W'($urandom_range(0, 65535)),
                          CFG_DATA_W'($urandom_range(0, 3000)));
        steady_flow = 1'b1;
        repeat (STEADY_WORDS) send_random_pixel();
        settle_block();
        steady_flow = 1'b0;
    endtask

    // Hold the result side while pixels keep coming so the input stalls on full
    task automatic test_input_backpressure();
        steady_flow      = 1'b1;
        mask_hold_cycles = PRESSURE_HOLD;
        repeat (PRESSURE_WORDS) send_random_pixel();
        settle_block();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        mode         = MODE_LOAD;
        pixel_index  = '0;
        chan_zero    = '0;
        chan_one     = '0;
        chan_two     = '0;
        chan_three   = '0;
        pop          = 1'b0;
        write_enable = 1'b0;
        reg_index    = REG_BLEND_RATE;
        write_data   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_limit_extremes();
        test_random_settings();
        test_steady_stream();
        test_input_backpressure();

        $display("Covered %0d pixel words: %0d loads, %0d subtracts, %0d masks checked (%0d fg).",
                 loads_sent + subtracts_sent, loads_sent, subtracts_sent, masks_checked,
                 fg_seen);
        $display("Register settings applied: %0d; input held by full for %0d cycles.",
                 settings_applied, full_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #WATCHDOG_NS;
        $display("Run timed out with %0d masks still pending.", mask_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
